[hw/rtl/tape_pulse_train_generator_top_assert.svh]
// Assertion macros used by the top level of the tape pulse train generator RTL.
`ifndef TAPE_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH
`define TAPE_PULSE_TRAIN_GENERATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define TPG_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define TPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TPG_ASSERT_SAME(label, clk, rstn, ante, cons, msg)
`define TPG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

[hw/rtl/tpg_pkg.sv]
// Types and constants of the tape pulse train generator.
`default_nettype none
package tpg_pkg;

    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_PILOT_RELOAD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_ONE_RELOAD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SYNC_TWO_RELOAD = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_BIT_RELOAD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ONE_BIT_RELOAD  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PILOT_COUNT     = 3'd5;

    // Item kinds; the fourth code is ignored.
    localparam logic [1:0] KIND_START  = 2'd0;
    localparam logic [1:0] KIND_EXPIRY = 2'd1;
    localparam logic [1:0] KIND_HALT   = 2'd2;

    localparam logic [4:0] HALF_BITS_PER_BYTE = 5'd16;

    typedef enum logic [2:0] {
        PH_PILOT = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_DATA  = 3'd3,
        PH_STOP  = 3'd4,
        PH_HALT  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [7:0]  pilot_reload;
        logic [7:0]  sync_one_reload;
        logic [7:0]  sync_two_reload;
        logic [7:0]  zero_bit_reload;
        logic [7:0]  one_bit_reload;
        logic [15:0] pilot_count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] block_length;
        logic [7:0]  next_byte;
    } item_t;

    typedef struct packed {
        logic        tape_level;
        logic [7:0]  reload_value;
        logic        byte_taken;
        logic        block_done;
        logic        running;
    } result_t;

endpackage
`default_nettype wire

[hw/rtl/tpg_cfg_regs.sv]
// Configuration register file of the tape pulse train generator.
`default_nettype none
module tpg_cfg_regs
    import tpg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_PILOT_RELOAD:    cfg_next.pilot_reload    = cfg_wdata[7:0];
                REG_SYNC_ONE_RELOAD: cfg_next.sync_one_reload = cfg_wdata[7:0];
                REG_SYNC_TWO_RELOAD: cfg_next.sync_two_reload = cfg_wdata[7:0];
                REG_ZERO_BIT_RELOAD: cfg_next.zero_bit_reload = cfg_wdata[7:0];
                REG_ONE_BIT_RELOAD:  cfg_next.one_bit_reload  = cfg_wdata[7:0];
                REG_PILOT_COUNT:     cfg_next.pilot_count     = cfg_wdata;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pilot_reload    <= 8'd100;
            cfg_reg.sync_one_reload <= 8'd208;
            cfg_reg.sync_two_reload <= 8'd203;
            cfg_reg.zero_bit_reload <= 8'd194;
            cfg_reg.one_bit_reload  <= 8'd133;
            cfg_reg.pilot_count     <= 16'd3225;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

[hw/rtl/tpg_step.sv]
// Phase state machine and next-result logic of the tape pulse train generator.
`default_nettype none
module tpg_step
    import tpg_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  step_en,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic        level_reg, level_next;
    logic        pin_reg, pin_next;
    logic [15:0] pilot_left_reg, pilot_left_next;
    logic [15:0] block_bytes_reg, block_bytes_next;
    logic [15:0] bytes_sent_reg, bytes_sent_next;
    logic [7:0]  shift_reg, shift_next;
    logic [4:0]  hbi_reg, hbi_next;

    logic [7:0]  reload;
    logic        taken;
    logic        done;
    logic        go;
    logic [7:0]  shift_eff;
    logic [4:0]  hbi_eff;

    always_comb begin
        phase_next       = phase_reg;
        level_next       = level_reg;
        pin_next         = pin_reg;
        pilot_left_next  = pilot_left_reg;
        block_bytes_next = block_bytes_reg;
        bytes_sent_next  = bytes_sent_reg;
        shift_next       = shift_reg;
        hbi_next         = hbi_reg;
        reload           = 8'd0;
        taken            = 1'b0;
        done             = 1'b0;
        go               = 1'b1;
        shift_eff        = shift_reg;
        hbi_eff          = hbi_reg;

        if (item.kind == KIND_START) begin
            block_bytes_next = item.block_length;
            pilot_left_next  = cfg.pilot_count;
            phase_next       = PH_PILOT;
        end else if (item.kind == KIND_HALT) begin
            phase_next = PH_HALT;
            level_next = 1'b0;
            pin_next   = 1'b0;
        end else if (item.kind == KIND_EXPIRY) begin
            unique case (phase_reg)
                PH_PILOT: begin
                    pin_next   = level_reg;
                    level_next = ~level_reg;
                    reload     = cfg.pilot_reload;
                    if (pilot_left_reg != 16'd0) begin
                        pilot_left_next = pilot_left_reg - 16'd1;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_SYNC1: begin
                    pin_next   = level_reg;
                    level_next = ~level_reg;
                    reload     = cfg.sync_one_reload;
                    phase_next = PH_SYNC2;
                end
                PH_SYNC2: begin
                    pin_next        = level_reg;
                    level_next      = ~level_reg;
                    reload          = cfg.sync_two_reload;
                    phase_next      = PH_DATA;
                    hbi_next        = HALF_BITS_PER_BYTE;
                    shift_next      = 8'd0;
                    bytes_sent_next = 16'd0;
                end
                PH_DATA: begin
                    pin_next   = level_reg;
                    level_next = ~level_reg;
                    if (hbi_reg >= HALF_BITS_PER_BYTE) begin
                        if (bytes_sent_reg >= block_bytes_reg) begin
                            phase_next = PH_STOP;
                            done       = 1'b1;
                            go         = 1'b0;
                        end else begin
                            hbi_eff         = 5'd0;
                            shift_eff       = item.next_byte;
                            bytes_sent_next = bytes_sent_reg + 16'd1;
                            taken           = 1'b1;
                        end
                    end
                    if (go) begin
                        reload     = shift_eff[7] ? cfg.one_bit_reload : cfg.zero_bit_reload;
                        shift_next = hbi_eff[0] ? {shift_eff[6:0], 1'b0} : shift_eff;
                        hbi_next   = hbi_eff + 5'd1;
                    end
                end
                default: begin
                    pin_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_STOP;
            level_reg       <= 1'b0;
            pin_reg         <= 1'b0;
            pilot_left_reg  <= 16'd0;
            block_bytes_reg <= 16'd0;
            bytes_sent_reg  <= 16'd0;
            shift_reg       <= 8'd0;
            hbi_reg         <= 5'd0;
        end else if (step_en) begin
            phase_reg       <= phase_next;
            level_reg       <= level_next;
            pin_reg         <= pin_next;
            pilot_left_reg  <= pilot_left_next;
            block_bytes_reg <= block_bytes_next;
            bytes_sent_reg  <= bytes_sent_next;
            shift_reg       <= shift_next;
            hbi_reg         <= hbi_next;
        end
    end

    assign res.tape_level   = pin_next;
    assign res.reload_value = reload;
    assign res.byte_taken   = taken;
    assign res.block_done   = done;
    assign res.running      = (phase_next < PH_STOP);

endmodule
`default_nettype wire

[hw/rtl/tape_pulse_train_generator_top.sv]
// Top level of the tape pulse train generator: input register, step logic, result register.
`default_nettype none
// The block turns a stream of events into the half-pulse train of one cassette
// block: a start transfer arms the pilot tone, each timer-expiry transfer returns
// the tape level to drive and the reload value for the next half-pulse, and a
// halt transfer stops playback with the level low. Every input transfer gives
// exactly one result transfer. An accepted item waits in the input register until
// the result register is free or being emptied, is then stepped through the phase
// state machine and lands in the result register, from which it is offered. One
// item is accepted per clock cycle for as long as results are taken; the phase
// state is updated at the same edge at which its result is registered, so
// back-to-back items need no gap.
// The result register frees the input side: a new item is taken while the last
// result still waits, and the input is held back only when both the input and the
// result registers are full and m_ready is low. The configuration registers are
// written through cfg_wr_en, cfg_index and cfg_wdata, by the user only while no item
// is in flight; the block does not check. Indexes beyond the pilot count are ignored.
module tape_pulse_train_generator_top
    import tpg_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [1:0]             s_kind,
    input  wire logic [15:0]            s_block_length,
    input  wire logic [7:0]             s_next_byte,

    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_tape_level,
    output logic [7:0]                  m_reload_value,
    output logic                        m_byte_taken,
    output logic                        m_block_done,
    output logic                        m_running
);

`include "tape_pulse_train_generator_top_assert.svh"

    cfg_t    cfg;
    result_t step_res;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg, in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg, out_res_next;

    logic    s_xfer;
    logic    fire;

    // An item is stepped when the result register is empty or being emptied.
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign s_xfer  = s_valid && s_ready;

    tpg_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tpg_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_comb begin
        in_item_next = in_item_reg;
        if (s_xfer) begin
            in_valid_next             = 1'b1;
            in_item_next.kind         = s_kind;
            in_item_next.block_length = s_block_length;
            in_item_next.next_byte    = s_next_byte;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_comb begin
        out_res_next = out_res_reg;
        if (fire) begin
            out_valid_next = 1'b1;
            out_res_next   = step_res;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_tape_level   = out_res_reg.tape_level;
    assign m_reload_value = out_res_reg.reload_value;
    assign m_byte_taken   = out_res_reg.byte_taken;
    assign m_block_done   = out_res_reg.block_done;
    assign m_running      = out_res_reg.running;

    // The end of a block leaves the generator stopped with no reload pending.
    `TPG_ASSERT_SAME(a_done_stops, aclk, aresetn, m_valid && m_block_done, !m_running && (m_reload_value == 8'd0), "block end while still running")
    // A byte is only consumed by the data phase, which then keeps running.
    `TPG_ASSERT_SAME(a_taken_running, aclk, aresetn, m_valid && m_byte_taken, m_running && !m_block_done, "byte consumed outside data phase")
    // A stopped or halted generator never asks for another half-pulse.
    `TPG_ASSERT_SAME(a_idle_no_reload, aclk, aresetn, m_valid && !m_running, m_reload_value == 8'd0, "reload given while stopped")
    // An item waiting in the input register is not dropped when stepping stalls.
    `TPG_ASSERT_NEXT(a_item_held, aclk, aresetn, in_valid_reg && !fire, in_valid_reg, "stalled item lost")
    // Every stepped item produces an offered result in the next cycle.
    `TPG_ASSERT_NEXT(a_fire_result, aclk, aresetn, fire, out_valid_reg, "stepped item gave no result")

endmodule
`default_nettype wire

[tb/tb_tape_pulse_train_generator_top.sv]
// Self-checking testbench for the tape pulse train generator top level.
`timescale 1ns / 1ps

module tb_tape_pulse_train_generator_top;
    import tpg_pkg::*;

    // The fourth item kind has no name in the package; the block ignores it.
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    // Generous bound on the length of the whole run.
    localparam int unsigned CYCLE_LIMIT = 300000;

    // One row of the directed script. When retune is set, the block is drained and
    // the extreme register set is loaded before the row is sent. When typed is set,
    // want holds the result read straight off the behaviour; otherwise the
    // predictor decides.
    typedef struct packed {
        logic    retune;
        item_t   stim;
        logic    typed;
        result_t want;
    } row_t;

    // Register sets at the ends of the ranges. The low set also has a pilot count
    // of zero, so a block reaches its sync and data phases in a few transfers.
    localparam cfg_t CFG_EDGE_A = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 16'd0};
    localparam cfg_t CFG_EDGE_B = '{8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 16'hFFFF};

    // Result fields are, in order: tape level, reload value, byte taken, block done,
    // running. The first eight rows run with the register values left by reset.
    localparam row_t TAPE_SCRIPT [26] = '{
        // An expiry while stopped, an ignored kind and a halt all leave the pin low.
        '{1'b0, '{KIND_EXPIRY,  16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
        '{1'b0, '{KIND_IGNORED, 16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
        '{1'b0, '{KIND_HALT,    16'hFFFF, 8'hFF}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
        // Start with the reset pilot count, then two pilot half-pulses.
        '{1'b0, '{KIND_START,   16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd100, 1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b1, 8'd100, 1'b0, 1'b0, 1'b1}},
        // A start while running keeps the pin where it is.
        '{1'b0, '{KIND_START,   16'h0000, 8'h00}, 1'b1, '{1'b1, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_HALT,    16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
        // Empty block with no pilot count: pilot end, both syncs, then the stop.
        '{1'b1, '{KIND_START,   16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b1, 8'd255, 1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd1,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b1, 8'd0,   1'b0, 1'b1, 1'b0}},
        // Once stopped, a further expiry drives the pin low.
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
        // Longest block: the first data byte is all ones, then a halt in mid-byte.
        '{1'b0, '{KIND_START,   16'hFFFF, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b1, 8'd255, 1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd1,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'hFF}, 1'b1, '{1'b1, 8'd255, 1'b1, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b0, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
        '{1'b0, '{KIND_HALT,    16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b0}},
        // One-byte block whose byte is all zeros.
        '{1'b0, '{KIND_START,   16'h0001, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd0,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b1, 8'd255, 1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b0, 8'd1,   1'b0, 1'b0, 1'b1}},
        '{1'b0, '{KIND_EXPIRY,  16'h0000, 8'h00}, 1'b1, '{1'b1, 8'd0,   1'b1, 1'b0, 1'b1}}
    };

    // Every input of the block starts at a known value.
    logic                   aclk           = 1'b0;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata      = '0;
    logic                   s_valid        = 1'b0;
    logic [1:0]             s_kind         = KIND_IGNORED;
    logic [15:0]            s_block_length = '0;
    logic [7:0]             s_next_byte    = '0;
    logic                   m_ready        = 1'b0;

    logic       s_ready;
    logic       m_valid;
    logic       m_tape_level;
    logic [7:0] m_reload_value;
    logic       m_byte_taken;
    logic       m_block_done;
    logic       m_running;

    // When calm is set, neither side idles, which gives a long stretch at full rate.
    bit calm = 1'b0;

    // Results still owed by the block, oldest first.
    result_t pulses_due [$];

    int unsigned cycle_count   = 0;
    int unsigned mismatches    = 0;
    int unsigned items_sent    = 0;
    int unsigned pulse_results = 0;
    int unsigned blocks_ended  = 0;
    int unsigned bytes_fetched = 0;
    int unsigned settings_used = 0;

    // The predictor's own copy of the registers and the playback state.
    cfg_t        cfg_shadow;
    phase_t      tape_phase;
    logic        level_pending;
    logic        pin_level;
    logic [15:0] pilot_remaining;
    logic [15:0] bytes_in_block;
    logic [15:0] bytes_done;
    logic [7:0]  shifter;
    logic [4:0]  half_bit;

    tape_pulse_train_generator_top dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_block_length (s_block_length),
        .s_next_byte    (s_next_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_tape_level   (m_tape_level),
        .m_reload_value (m_reload_value),
        .m_byte_taken   (m_byte_taken),
        .m_block_done   (m_block_done),
        .m_running      (m_running)
    );

    // 8 ns clock period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Steps the predictor by one accepted item and returns the result it causes.
    // The pending level is driven on every expiry while a block plays; the data
    // phase spends two half-pulses on each bit, most significant bit first.
    function automatic result_t advance_tape(input item_t it);
        result_t r;
        r = '0;
        case (it.kind)
            KIND_START: begin
                bytes_in_block  = it.block_length;
                pilot_remaining = cfg_shadow.pilot_count;
                tape_phase      = PH_PILOT;
            end
            KIND_HALT: begin
                tape_phase    = PH_HALT;
                level_pending = 1'b0;
                pin_level     = 1'b0;
            end
            KIND_EXPIRY: begin
                if (tape_phase >= PH_STOP) begin
                    pin_level = 1'b0;
                end else begin
                    pin_level     = level_pending;
                    level_pending = ~level_pending;
                    case (tape_phase)
                        PH_PILOT: begin
                            r.reload_value = cfg_shadow.pilot_reload;
                            if (pilot_remaining != 16'd0) begin
                                pilot_remaining = pilot_remaining - 16'd1;
                            end else begin
                                tape_phase = PH_SYNC1;
                            end
                        end
                        PH_SYNC1: begin
                            r.reload_value = cfg_shadow.sync_one_reload;
                            tape_phase     = PH_SYNC2;
                        end
                        PH_SYNC2: begin
                            r.reload_value = cfg_shadow.sync_two_reload;
                            tape_phase     = PH_DATA;
                            half_bit       = HALF_BITS_PER_BYTE;
                            shifter        = 8'd0;
                            bytes_done     = 16'd0;
                        end
                        default: begin
                            if (half_bit >= HALF_BITS_PER_BYTE && bytes_done >= bytes_in_block) begin
                                tape_phase   = PH_STOP;
                                r.block_done = 1'b1;
                            end else begin
                                // A fresh byte is fetched once the last one is used up.
                                if (half_bit >= HALF_BITS_PER_BYTE) begin
                                    half_bit     = 5'd0;
                                    shifter      = it.next_byte;
                                    bytes_done   = bytes_done + 16'd1;
                                    r.byte_taken = 1'b1;
                                end
                                r.reload_value = shifter[7] ? cfg_shadow.one_bit_reload
                                                            : cfg_shadow.zero_bit_reload;
                                if (half_bit[0]) begin
                                    shifter = shifter << 1;
                                end
                                half_bit = half_bit + 5'd1;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        r.tape_level = pin_level;
        r.running    = (tape_phase < PH_STOP);
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Offers one item, holding it until the transfer happens, and records what it
    // should produce. The sender idles at random before the item unless calm.
    task automatic send_item(input item_t it, input bit typed = 1'b0,
                             input result_t want = '0);
        result_t predicted;
        while (!calm && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_kind         <= it.kind;
        s_block_length <= it.block_length;
        s_next_byte    <= it.next_byte;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = advance_tape(it);
        pulses_due.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Stops offering items and waits until every owed result has been taken. The
    // queue is sampled on the falling edge, away from the edge on which it changes.
    task automatic wait_for_pulses();
        s_valid <= 1'b0;
        while (pulses_due.size() != 0) begin
            @(negedge aclk);
        end
        @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Writes all six registers; the block must be idle when this is called.
    task automatic load_settings(input cfg_t c);
        write_reg(REG_PILOT_RELOAD,    {8'h00, c.pilot_reload});
        write_reg(REG_SYNC_ONE_RELOAD, {8'h00, c.sync_one_reload});
        write_reg(REG_SYNC_TWO_RELOAD, {8'h00, c.sync_two_reload});
        write_reg(REG_ZERO_BIT_RELOAD, {8'h00, c.zero_bit_reload});
        write_reg(REG_ONE_BIT_RELOAD,  {8'h00, c.one_bit_reload});
        write_reg(REG_PILOT_COUNT,     c.pilot_count);
        cfg_wr_en  <= 1'b0;
        cfg_shadow = c;
        settings_used++;
    endtask

    // Random playback: mostly whole blocks, each a start followed by expiries
    // until the block stops, with halts, restarts and ignored items mixed in as
    // noise. Blocks are kept short so that most of them run to their end; a start
    // now and then carries a full random length; halts, restarts or a cap cut it short.
    task automatic play_blocks(input int unsigned budget);
        int unsigned sent;
        int unsigned spent;
        int unsigned roll;
        item_t       it;
        sent = 0;
        while (sent < budget) begin
            it.kind         = KIND_START;
            it.block_length = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 3))
                                                           : 16'($urandom);
            it.next_byte    = 8'($urandom);
            send_item(it);
            sent++;
            spent = 0;
            while (tape_phase < PH_STOP && sent < budget && spent < 150) begin
                roll            = $urandom_range(0, 99);
                it.block_length = 16'($urandom);
                it.next_byte    = 8'($urandom);
                if (roll < 94) begin
                    it.kind = KIND_EXPIRY;
                end else if (roll < 96) begin
                    it.kind = KIND_HALT;
                end else if (roll < 98) begin
                    it.kind = KIND_START;
                end else begin
                    it.kind = KIND_IGNORED;
                end
                send_item(it);
                spent++;
                if (it.kind != KIND_IGNORED) begin
                    sent++;
                end
            end
            // A few stray items between blocks, of any kind.
            repeat ($urandom_range(0, 2)) begin
                it.kind         = 2'($urandom);
                it.block_length = 16'($urandom);
                it.next_byte    = 8'($urandom);
                send_item(it);
                if (it.kind != KIND_IGNORED) begin
                    sent++;
                end
            end
            // Now and then the sender holds off until the block has caught up.
            if ($urandom_range(0, 24) == 0) begin
                wait_for_pulses();
            end
        end
    endtask

    // The receiver stalls in about one cycle in six, except during the calm stretch.
    always @(posedge aclk) begin
        m_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
    end

    // Every result transfer is compared with the oldest owed result, field by field.
    always @(posedge aclk) begin : watch_results
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pulses_due.size() == 0) begin
                $error("result transfer arrived with no item outstanding");
                mismatches++;
            end else begin
                want = pulses_due.pop_front();
                check_field("tape_level",   want.tape_level,   m_tape_level);
                check_field("reload_value", want.reload_value, m_reload_value);
                check_field("byte_taken",   want.byte_taken,   m_byte_taken);
                check_field("block_done",   want.block_done,   m_block_done);
                check_field("running",      want.running,      m_running);
                pulse_results++;
                blocks_ended  += m_block_done;
                bytes_fetched += m_byte_taken;
            end
        end
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Run stopped by the watchdog after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin : main_sequence
        cfg_t mix;
        // The predictor starts from the state that reset leaves in the block.
        cfg_shadow      = '{8'd100, 8'd208, 8'd203, 8'd194, 8'd133, 16'd3225};
        tape_phase      = PH_STOP;
        level_pending   = 1'b0;
        pin_level       = 1'b0;
        pilot_remaining = '0;
        bytes_in_block  = '0;
        bytes_done      = '0;
        shifter         = '0;
        half_bit        = '0;

        // Synchronous reset, held from time zero and released on a rising edge.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed script: reset values first, then the extreme register set.
        for (int i = 0; i < 26; i++) begin
            if (TAPE_SCRIPT[i].retune) begin
                wait_for_pulses();
                load_settings(CFG_EDGE_A);
            end
            send_item(TAPE_SCRIPT[i].stim, TAPE_SCRIPT[i].typed, TAPE_SCRIPT[i].want);
        end

        // Random phases, each under its own register values. The first uses the
        // other extreme set, whose pilot tone never ends within the phase, so it is
        // kept short. The fourth runs with neither side idling.
        for (int p = 0; p < 6; p++) begin
            wait_for_pulses();
            if (p == 0) begin
                mix = CFG_EDGE_B;
            end else begin
                mix.pilot_reload    = 8'($urandom);
                mix.sync_one_reload = 8'($urandom);
                mix.sync_two_reload = 8'($urandom);
                mix.zero_bit_reload = 8'($urandom);
                mix.one_bit_reload  = 8'($urandom);
                mix.pilot_count     = (p == 5) ? 16'($urandom_range(13, 40))
                                               : 16'($urandom_range(0, 12));
            end
            load_settings(mix);
            calm <= (p == 3);
            play_blocks((p == 0) ? 60 : 378);
        end
        calm <= 1'b0;

        // Drain, then keep clocking so that any stray result can show itself.
        wait_for_pulses();
        repeat (8) @(posedge aclk);

        $display("Sent %0d items under %0d register settings; checked %0d results.",
                 items_sent, settings_used, pulse_results);
        $display("Blocks played to their end: %0d, data bytes fetched: %0d.",
                 blocks_ended, bytes_fetched);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
